[hw/rtl/cdlv_pkg.sv]
package cdlv_pkg;

  localparam int MAX_CLOCKS_DEF = 8;
  localparam int MAX_LEVELS_DEF = 8;

  // holds counts and levels up to 31
  localparam int NW         = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 4;
  localparam int ACT_W      = 4;

  localparam logic [CFG_IDX_W-1:0] REG_CLOCK_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_COUNT = 1'd1;

  localparam logic [1:0] OP_SET_RATE  = 2'd0;
  localparam logic [1:0] OP_UNPREPARE = 2'd1;
  localparam logic [1:0] OP_WR_THRESH = 2'd2;
  localparam logic [1:0] OP_WR_LEVEL  = 2'd3;

  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_VOTE   = 1'b1;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [2:0]  clock_index;
    logic [2:0]  level_index;
    logic [31:0] frequency;
    logic [7:0]  channel_number;
    logic [15:0] voltage_code;
  } in_word_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  vote_channel;
    logic        vote_enable;
    logic [15:0] vote_voltage;
    logic        status;
    logic [3:0]  active_level;
    logic        last;
  } out_word_t;

  typedef struct packed {
    logic [7:0]  ch;
    logic [15:0] volt;
  } lvl_ent_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DEC,
    S_SRCH,
    S_ZCHK,
    S_MOVE,
    S_RDN,
    S_RDO,
    S_VN,
    S_VO,
    S_ST
  } state_t;

  typedef struct packed {
    logic ld_item;
    logic rate_wr;
    logic rate_clr;
    logic thr_wr;
    logic lvl_wr;
    logic srch_init;
    logic tgt_srch;
    logic tgt_off;
    logic lvl_move;
    logic rd_new;
    logic rd_old;
    logic emit_vn;
    logic emit_vo;
    logic emit_st;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       ci_ok;
    logic       all_zero;
    logic       srch_done;
    logic       same_lvl;
    logic       has_new;
    logic       has_old;
    logic       same_ch;
  } sts_t;

endpackage

[hw/rtl/combined_dvfs_level_voter_top.sv]
// Channel  Ports                              Handshake
// input    start, busy, in_word               taken when start && !busy
// result   out_valid, out_word                one-cycle strobe, no back-pressure
// config   cfg_we, cfg_index, cfg_wdata       taken when cfg_we
//
// Table writes and rejected ops: accept, decode, then the status word.
// Set rate: the level search reads one threshold per cycle from its memory,
// every clock in use at each level in turn, and stops at the first level
// that fits every rate; with no match it takes the top level in use.
// Reset: synchronous, active low; rates clear, level goes to disabled.
// One item at a time; busy stays high until the last word is issued.
module combined_dvfs_level_voter_top #(
  parameter int MAX_CLOCKS = cdlv_pkg::MAX_CLOCKS_DEF,
  parameter int MAX_LEVELS = cdlv_pkg::MAX_LEVELS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [cdlv_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cdlv_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                            start,
  output logic                            busy,
  input  cdlv_pkg::in_word_t              in_word,
  output logic                            out_valid,
  output cdlv_pkg::out_word_t             out_word
);
  import cdlv_pkg::*;

  cmd_t cmd;
  sts_t sts;

  cdlv_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .busy  (busy),
    .cmd   (cmd)
  );

  cdlv_dp #(
    .MAX_CLOCKS (MAX_CLOCKS),
    .MAX_LEVELS (MAX_LEVELS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_word   (in_word),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after accept");

  a_last_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_word.last) |-> $past(busy))
    else $error("final word without an item in flight");

  a_idle_only_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!busy && out_valid) |-> out_word.last)
    else $error("vote word issued after item completed");

  a_vote_followed: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_word.kind == KIND_VOTE)) |=> out_valid)
    else $error("vote word not followed by another word");

endmodule

[hw/rtl/cdlv_ctrl.sv]
module cdlv_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  cdlv_pkg::sts_t sts,
  output logic           busy,
  output cdlv_pkg::cmd_t cmd
);
  import cdlv_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b1;
    case (state_r)
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.ld_item = 1'b1;
          state_nxt   = S_DEC;
        end
      end
      S_DEC: begin
        state_nxt = S_ST;
        case (sts.op)
          OP_SET_RATE: begin
            if (sts.ci_ok) begin
              cmd.rate_wr   = 1'b1;
              cmd.srch_init = 1'b1;
              state_nxt     = S_SRCH;
            end
          end
          OP_UNPREPARE: begin
            if (sts.ci_ok) begin
              cmd.rate_clr = 1'b1;
              state_nxt    = S_ZCHK;
            end
          end
          OP_WR_THRESH: cmd.thr_wr = 1'b1;
          OP_WR_LEVEL:  cmd.lvl_wr = 1'b1;
          default: ;
        endcase
      end
      S_ZCHK: begin
        if (sts.all_zero) begin
          cmd.tgt_off = 1'b1;
          state_nxt   = S_MOVE;
        end else begin
          state_nxt = S_ST;
        end
      end
      S_SRCH: begin
        if (sts.srch_done) begin
          cmd.tgt_srch = 1'b1;
          state_nxt    = S_MOVE;
        end
      end
      S_MOVE: begin
        if (sts.same_lvl) begin
          state_nxt = S_ST;
        end else begin
          cmd.lvl_move = 1'b1;
          cmd.rd_new   = 1'b1;
          state_nxt    = S_RDN;
        end
      end
      S_RDN: begin
        cmd.rd_old = 1'b1;
        state_nxt  = S_RDO;
      end
      S_RDO: begin
        if (sts.has_new && sts.has_old && sts.same_ch) begin
          state_nxt = S_ST;
        end else if (sts.has_new) begin
          state_nxt = S_VN;
        end else if (sts.has_old) begin
          state_nxt = S_VO;
        end else begin
          state_nxt = S_ST;
        end
      end
      S_VN: begin
        cmd.emit_vn = 1'b1;
        state_nxt   = sts.has_old ? S_VO : S_ST;
      end
      S_VO: begin
        cmd.emit_vo = 1'b1;
        state_nxt   = S_ST;
      end
      S_ST: begin
        cmd.emit_st = 1'b1;
        state_nxt   = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

[hw/rtl/cdlv_dp.sv]
module cdlv_dp #(
  parameter int MAX_CLOCKS = cdlv_pkg::MAX_CLOCKS_DEF,
  parameter int MAX_LEVELS = cdlv_pkg::MAX_LEVELS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [cdlv_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cdlv_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  cdlv_pkg::in_word_t                  in_word,
  input  cdlv_pkg::cmd_t                      cmd,
  output cdlv_pkg::sts_t                      sts,
  output logic                                out_valid,
  output cdlv_pkg::out_word_t                 out_word
);
  import cdlv_pkg::*;

  localparam int CIW    = (MAX_CLOCKS > 1) ? $clog2(MAX_CLOCKS) : 1;
  localparam int LIW    = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
  localparam int TDEPTH = MAX_CLOCKS * MAX_LEVELS;
  localparam int TW     = (TDEPTH > 1) ? $clog2(TDEPTH) : 1;
  localparam logic [NW-1:0] NC_MAX  = NW'(MAX_CLOCKS);
  localparam logic [NW-1:0] NL_MAX  = NW'(MAX_LEVELS);
  localparam logic [NW-1:0] LVL_OFF = NW'(MAX_LEVELS);

  logic [CFG_DATA_W-1:0] ccnt_r, lcnt_r;
  in_word_t              item_r;
  logic [31:0]           rates_r [MAX_CLOCKS];
  logic [NW-1:0]         cur_r, prev_r, tgt_r;

  logic                  iss_on_r, d_vld_r, d_last_r, fail_r, found_r;
  logic [NW-1:0]         sl_r, sc_r, d_lvl_r, d_clk_r, fnd_lvl_r;
  logic [31:0]           thr_rd_r;
  logic [31:0]           thr_mem [TDEPTH];

  lvl_ent_t              lvl_mem [MAX_LEVELS];
  lvl_ent_t              lv_rd_r, new_r;

  logic                  out_valid_r;
  out_word_t             out_word_r;

  logic [NW-1:0] nc, nl, ci_n, li_n, srch_lvl;
  logic          ci_ok, thr_wr_ok, all_zero, srch_done, bad, cmp_fail;
  logic [TW-1:0] thr_waddr, iss_addr;

  always_comb begin
    nc        = (NW'(ccnt_r) > NC_MAX) ? NC_MAX : NW'(ccnt_r);
    nl        = (NW'(lcnt_r) > NL_MAX) ? NL_MAX : NW'(lcnt_r);
    ci_n      = NW'(item_r.clock_index);
    li_n      = NW'(item_r.level_index);
    ci_ok     = ci_n < nc;
    thr_wr_ok = (ci_n < NC_MAX) && (li_n < NL_MAX);
    thr_waddr = TW'(li_n * MAX_CLOCKS + ci_n);
    iss_addr  = TW'(sl_r * MAX_CLOCKS + sc_r);
    bad       = (item_r.opcode inside {OP_SET_RATE, OP_UNPREPARE}) && !ci_ok;
    srch_done = found_r || (!iss_on_r && !d_vld_r);
    if (found_r) begin
      srch_lvl = fnd_lvl_r;
    end else if (nl == '0) begin
      srch_lvl = '0;
    end else begin
      srch_lvl = nl - NW'(1);
    end
    cmp_fail = fail_r || (rates_r[d_clk_r[CIW-1:0]] > thr_rd_r);
  end

  always_comb begin
    all_zero = 1'b1;
    for (int j = 0; j < MAX_CLOCKS; j++) begin
      if ((NW'(j) < nc) && (rates_r[j] != '0)) begin
        all_zero = 1'b0;
      end
    end
  end

  always_comb begin
    sts.op        = item_r.opcode;
    sts.ci_ok     = ci_ok;
    sts.all_zero  = all_zero;
    sts.srch_done = srch_done;
    sts.same_lvl  = tgt_r == cur_r;
    sts.has_new   = cur_r < NL_MAX;
    sts.has_old   = prev_r < NL_MAX;
    sts.same_ch   = new_r.ch == lv_rd_r.ch;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ccnt_r      <= CFG_DATA_W'(1);
      lcnt_r      <= CFG_DATA_W'(1);
      cur_r       <= LVL_OFF;
      prev_r      <= LVL_OFF;
      tgt_r       <= LVL_OFF;
      iss_on_r    <= 1'b0;
      d_vld_r     <= 1'b0;
      fail_r      <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
      for (int j = 0; j < MAX_CLOCKS; j++) begin
        rates_r[j] <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_CLOCK_COUNT: ccnt_r <= cfg_wdata;
          REG_LEVEL_COUNT: lcnt_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (cmd.rate_wr) begin
        rates_r[ci_n[CIW-1:0]] <= item_r.frequency;
      end
      if (cmd.rate_clr) begin
        rates_r[ci_n[CIW-1:0]] <= '0;
      end
      if (cmd.tgt_srch) begin
        tgt_r <= srch_lvl;
      end
      if (cmd.tgt_off) begin
        tgt_r <= LVL_OFF;
      end
      if (cmd.lvl_move) begin
        prev_r <= cur_r;
        cur_r  <= tgt_r;
      end

      if (cmd.srch_init) begin
        iss_on_r <= nl != '0;
        d_vld_r  <= 1'b0;
        fail_r   <= 1'b0;
        found_r  <= 1'b0;
      end else begin
        d_vld_r <= iss_on_r;
        if (iss_on_r && (sc_r == nc - NW'(1)) && (sl_r == nl - NW'(1))) begin
          iss_on_r <= 1'b0;
        end
        if (found_r) begin
          iss_on_r <= 1'b0;
        end
        if (d_vld_r && !found_r) begin
          if (d_last_r) begin
            fail_r <= 1'b0;
            if (!cmp_fail) begin
              found_r  <= 1'b1;
              iss_on_r <= 1'b0;
            end
          end else begin
            fail_r <= cmp_fail;
          end
        end
      end

      out_valid_r <= cmd.emit_vn || cmd.emit_vo || cmd.emit_st;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_item) begin
      item_r <= in_word;
    end
    if (cmd.srch_init) begin
      sl_r <= '0;
      sc_r <= '0;
    end else if (iss_on_r) begin
      d_lvl_r  <= sl_r;
      d_clk_r  <= sc_r;
      d_last_r <= sc_r == nc - NW'(1);
      if (sc_r == nc - NW'(1)) begin
        sc_r <= '0;
        sl_r <= sl_r + NW'(1);
      end else begin
        sc_r <= sc_r + NW'(1);
      end
    end
    if (d_vld_r && !found_r && d_last_r && !cmp_fail) begin
      fnd_lvl_r <= d_lvl_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.thr_wr && thr_wr_ok) begin
      thr_mem[thr_waddr] <= item_r.frequency;
    end
    if (iss_on_r) begin
      thr_rd_r <= thr_mem[iss_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.lvl_wr && (li_n < NL_MAX)) begin
      lvl_mem[li_n[LIW-1:0]] <= '{ch: item_r.channel_number, volt: item_r.voltage_code};
    end
    if (cmd.rd_new) begin
      lv_rd_r <= lvl_mem[tgt_r[LIW-1:0]];
    end
    if (cmd.rd_old) begin
      new_r   <= lv_rd_r;
      lv_rd_r <= lvl_mem[prev_r[LIW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_vn || cmd.emit_vo || cmd.emit_st) begin
      out_word_r              <= '0;
      out_word_r.active_level <= ACT_W'(cur_r);
      if (cmd.emit_vn) begin
        out_word_r.kind         <= KIND_VOTE;
        out_word_r.vote_channel <= new_r.ch;
        out_word_r.vote_enable  <= 1'b1;
        out_word_r.vote_voltage <= new_r.volt;
      end else if (cmd.emit_vo) begin
        out_word_r.kind         <= KIND_VOTE;
        out_word_r.vote_channel <= lv_rd_r.ch;
      end else begin
        out_word_r.kind   <= KIND_STATUS;
        out_word_r.status <= bad;
        out_word_r.last   <= 1'b1;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;
  import cdlv_pkg::*;

  localparam int NCLK = MAX_CLOCKS_DEF;
  localparam int NLVL = MAX_LEVELS_DEF;
  localparam logic [3:0] LEVEL_OFF = 4'(NLVL);

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  start = 1'b0;
  logic                  busy;
  in_word_t              in_word = '0;
  logic                  out_valid;
  out_word_t             out_word;

  // voter state as seen by the testbench
  logic [31:0] rate_tab [NCLK];
  logic [31:0] thr_tab [NLVL][NCLK];
  logic [7:0]  chan_tab [NLVL];
  logic [15:0] volt_tab [NLVL];
  logic [3:0]  level_now = LEVEL_OFF;
  logic [3:0]  clk_cnt = 4'd1;
  logic [3:0]  lvl_cnt = 4'd1;

  out_word_t owed_words[$];
  out_word_t want;
  int        errs = 0;
  bit        quiet = 1'b0;

  combined_dvfs_level_voter_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .start     (start),
    .busy      (busy),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

  always #2 clk = ~clk;

  initial begin
    foreach (rate_tab[i]) rate_tab[i] = '0;
  end

  function automatic int clocks_in_use();
    return (clk_cnt > NCLK) ? NCLK : int'(clk_cnt);
  endfunction

  function automatic int levels_in_use();
    return (lvl_cnt > NLVL) ? NLVL : int'(lvl_cnt);
  endfunction

  function automatic logic [3:0] best_level();
    int  nc;
    int  nl;
    bit  fits;
    nc = clocks_in_use();
    nl = levels_in_use();
    if (nl == 0) return 4'd0;
    for (int i = 0; i < nl; i++) begin
      fits = 1'b1;
      for (int j = 0; j < nc; j++) begin
        if (rate_tab[j] > thr_tab[i][j]) fits = 1'b0;
      end
      if (fits) return 4'(i);
    end
    return 4'(nl - 1);
  endfunction

  function automatic void push_vote(logic [7:0] ch, logic en, logic [15:0] v, logic [3:0] lv);
    out_word_t r;
    r = '0;
    r.kind         = KIND_VOTE;
    r.vote_channel = ch;
    r.vote_enable  = en;
    r.vote_voltage = v;
    r.active_level = lv;
    owed_words.push_back(r);
  endfunction

  function automatic void move_level(logic [3:0] nxt);
    logic [3:0] prev;
    prev = level_now;
    if (nxt == prev) return;
    level_now = nxt;
    if (nxt < LEVEL_OFF && prev < LEVEL_OFF && chan_tab[nxt] == chan_tab[prev]) return;
    if (nxt < LEVEL_OFF) push_vote(chan_tab[nxt], 1'b1, volt_tab[nxt], nxt);
    if (prev < LEVEL_OFF) push_vote(chan_tab[prev], 1'b0, 16'd0, nxt);
  endfunction

  function automatic void apply_request(in_word_t w);
    out_word_t r;
    logic      st;
    bit        any_rate;
    int        nc;
    st = 1'b0;
    nc = clocks_in_use();
    case (w.opcode)
      OP_SET_RATE, OP_UNPREPARE: begin
        if (int'(w.clock_index) >= nc) begin
          st = 1'b1;
        end else if (w.opcode == OP_SET_RATE) begin
          rate_tab[w.clock_index] = w.frequency;
          move_level(best_level());
        end else begin
          rate_tab[w.clock_index] = '0;
          any_rate = 1'b0;
          for (int j = 0; j < nc; j++) begin
            if (rate_tab[j] != 0) any_rate = 1'b1;
          end
          if (!any_rate) move_level(LEVEL_OFF);
        end
      end
      OP_WR_THRESH: thr_tab[w.level_index][w.clock_index] = w.frequency;
      default: begin
        chan_tab[w.level_index] = w.channel_number;
        volt_tab[w.level_index] = w.voltage_code;
      end
    endcase
    r = '0;
    r.kind         = KIND_STATUS;
    r.status       = st;
    r.active_level = level_now;
    r.last         = 1'b1;
    owed_words.push_back(r);
  endfunction

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, got_v);
      errs++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (owed_words.size() == 0) begin
        $error("word with none owed: %p", out_word);
        errs++;
      end else begin
        want = owed_words.pop_front();
        check_field("kind", 32'(want.kind), 32'(out_word.kind));
        check_field("vote_channel", 32'(want.vote_channel), 32'(out_word.vote_channel));
        check_field("vote_enable", 32'(want.vote_enable), 32'(out_word.vote_enable));
        check_field("vote_voltage", 32'(want.vote_voltage), 32'(out_word.vote_voltage));
        check_field("status", 32'(want.status), 32'(out_word.status));
        check_field("active_level", 32'(want.active_level), 32'(out_word.active_level));
        check_field("last", 32'(want.last), 32'(out_word.last));
      end
    end
  end

  task automatic issue_word(in_word_t w);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (busy);
    apply_request(w);
  endtask

  task automatic send_op(logic [1:0] op, logic [2:0] ci, logic [2:0] li, logic [31:0] f,
                         logic [7:0] ch = 8'h00, logic [15:0] v = 16'h0000);
    in_word_t w;
    w.opcode         = op;
    w.clock_index    = ci;
    w.level_index    = li;
    w.frequency      = f;
    w.channel_number = ch;
    w.voltage_code   = v;
    issue_word(w);
  endtask

  task automatic settle();
    start <= 1'b0;
    while (owed_words.size() != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_CLOCK_COUNT) clk_cnt = val;
    else lvl_cnt = val;
  endtask

  task automatic set_counts(logic [3:0] cc, logic [3:0] lc);
    settle();
    write_reg(REG_CLOCK_COUNT, cc);
    write_reg(REG_LEVEL_COUNT, lc);
  endtask

  // reset defaults: one clock, one level, no table reads allowed yet
  task automatic test_reset_rejects();
    send_op(OP_SET_RATE, 3'd1, 3'd0, 32'h1234_5678);
    send_op(OP_UNPREPARE, 3'd7, 3'd0, 32'h0);
    send_op(OP_UNPREPARE, 3'd0, 3'd0, 32'h0);
  endtask

  // thresholds rise with level; levels 2 and 3 share a supply
  task automatic test_table_load();
    logic [31:0] f;
    logic [7:0]  ch;
    for (int l = 0; l < NLVL; l++) begin
      for (int c = 0; c < NCLK; c++) begin
        f = (l == NLVL - 1) ? 32'hFFFF_FFFF : 32'(l) * 32'h2000_0000 + 32'h1FFF_FFFF;
        send_op(OP_WR_THRESH, 3'(c), 3'(l), f);
      end
      ch = (l == 3) ? 8'h25 : 8'h10 * 8'(l) + 8'h05;
      send_op(OP_WR_LEVEL, 3'd0, 3'(l), 32'h0, ch, (l == 0) ? 16'h0 : 16'h1FFF * 16'(l) + 16'h1);
    end
  endtask

  task automatic test_level_moves();
    set_counts(4'd8, 4'd8);
    send_op(OP_SET_RATE, 3'd0, 3'd0, 32'h0);
    send_op(OP_SET_RATE, 3'd7, 3'd0, 32'hFFFF_FFFF);
    send_op(OP_SET_RATE, 3'd7, 3'd0, 32'h6000_0000);
    send_op(OP_SET_RATE, 3'd7, 3'd0, 32'h5000_0000);
    send_op(OP_SET_RATE, 3'd7, 3'd0, 32'h5000_0000);
    send_op(OP_SET_RATE, 3'd3, 3'd0, 32'h5FFF_FFFF);
    send_op(OP_UNPREPARE, 3'd7, 3'd0, 32'h0);
    send_op(OP_UNPREPARE, 3'd3, 3'd0, 32'h0);
    send_op(OP_UNPREPARE, 3'd0, 3'd0, 32'h0);
  endtask

  task automatic test_count_limits();
    set_counts(4'd2, 4'd3);
    send_op(OP_SET_RATE, 3'd1, 3'd0, 32'hF000_0000);
    send_op(OP_SET_RATE, 3'd2, 3'd0, 32'h1);
    set_counts(4'd2, 4'd0);
    send_op(OP_SET_RATE, 3'd0, 3'd0, 32'hFFFF_FFFF);
    set_counts(4'd0, 4'd0);
    send_op(OP_SET_RATE, 3'd0, 3'd0, 32'h1);
    send_op(OP_UNPREPARE, 3'd0, 3'd0, 32'h0);
    set_counts(4'd15, 4'd9);
    send_op(OP_SET_RATE, 3'd7, 3'd0, 32'h0);
    send_op(OP_WR_THRESH, 3'd7, 3'd7, 32'h0);
    send_op(OP_WR_LEVEL, 3'd0, 3'd7, 32'h0, 8'hFF, 16'hFFFF);
    send_op(OP_WR_LEVEL, 3'd0, 3'd0, 32'h0, 8'h00, 16'h0000);
    send_op(OP_WR_THRESH, 3'd0, 3'd0, 32'hFFFF_FFFF);
    send_op(OP_SET_RATE, 3'd0, 3'd0, 32'h1);
  endtask

  task automatic test_random_traffic();
    logic [3:0] cc_list [8] = '{4'd8, 4'd1, 4'd3, 4'd8, 4'd2, 4'd15, 4'd0, 4'd8};
    logic [3:0] lc_list [8] = '{4'd8, 4'd1, 4'd5, 4'd2, 4'd8, 4'd9, 4'd4, 4'd0};
    in_word_t   w;
    int         sent;
    int         nc;
    int         pick;
    int         lv;
    for (int ph = 0; ph < 10; ph++) begin
      quiet = 1'b0;
      if (ph < 8) set_counts(cc_list[ph], lc_list[ph]);
      else set_counts(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
      quiet = ($urandom_range(0, 3) == 0);
      nc = clocks_in_use();
      sent = 0;
      while (sent < 20) begin
        w.opcode         = 2'($urandom);
        w.clock_index    = 3'($urandom);
        w.level_index    = 3'($urandom);
        w.frequency      = $urandom;
        w.channel_number = 8'($urandom);
        w.voltage_code   = 16'($urandom);
        lv   = $urandom_range(0, NLVL - 1);
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
          w.opcode = OP_SET_RATE;
          if (nc > 0 && $urandom_range(0, 9) != 0) begin
            w.clock_index = 3'($urandom_range(0, nc - 1));
          end
          case ($urandom_range(0, 3))
            0: w.frequency = 32'h0;
            1: ;
            default: w.frequency = thr_tab[lv][w.clock_index] + $urandom_range(0, 2) - 1;
          endcase
          issue_word(w);
          sent++;
        end else if (pick < 68) begin
          // release clocks one by one so the domain can drop to off
          w.opcode = OP_UNPREPARE;
          for (int j = 0; j < ((nc > 0) ? nc : 1); j++) begin
            w.clock_index = 3'(j);
            issue_word(w);
            sent++;
          end
        end else if (pick < 82) begin
          w.opcode = OP_WR_THRESH;
          if ($urandom_range(0, 1)) begin
            w.frequency = thr_tab[lv][w.clock_index] ^ 32'($urandom_range(0, 255));
          end
          issue_word(w);
          sent++;
        end else if (pick < 96) begin
          w.opcode = OP_WR_LEVEL;
          if ($urandom_range(0, 1)) w.channel_number = 8'($urandom_range(0, 3));
          issue_word(w);
          sent++;
        end else begin
          settle();
        end
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_rejects();
    test_table_load();
    test_level_moves();
    test_count_limits();
    test_random_traffic();
    settle();
    repeat (80) @(posedge clk);
    if (errs == 0) begin
      $display("combined_dvfs_level_voter_top verification clean");
    end else begin
      $display("combined_dvfs_level_voter_top verification failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("combined_dvfs_level_voter_top verification failed");
    $finish;
  end

endmodule

[files.f]
hw/rtl/cdlv_pkg.sv
hw/rtl/cdlv_ctrl.sv
hw/rtl/cdlv_dp.sv
hw/rtl/combined_dvfs_level_voter_top.sv
tb/tb.sv
